// ----- hdl/pvcd_pkg.sv -----
// Package for the polyline view cull and decimate block.
// Holds the word types, register indexes and constants shared by the block, its checks and the testbench.
// No dependencies.
package pvcd_pkg;

   // Coordinate width used inside the block by default.
   localparam int COORD_BITS_DEF = 32;

   // Width of the coordinate fields on the channels.
   localparam int WORD_W = 32;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] VIEW_WIDTH_RESET  = 16'd640;
   localparam logic [CSR_DATA_W-1:0] VIEW_HEIGHT_RESET = 16'd480;

   // Result actions.
   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_CLOSE  = 1'b1;

   // Decimation radius: per-axis limit and squared distance.
   localparam int NEAR_DIST = 8;
   localparam int NEAR_SQ   = 64;

   // Most results that one vertex can cause.
   localparam int RES_MAX = 4;

   // Input word: one vertex.
   typedef struct packed {
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic                     last_point;
   } req_word_type;

   // Output word: one append or close command.
   typedef struct packed {
      logic signed [WORD_W-1:0] vertex_x;
      logic signed [WORD_W-1:0] vertex_y;
      logic                     action;
      logic                     run_last;
   } rsp_word_type;

   // One buffered result before the run_last marker is attached.
   typedef struct packed {
      logic signed [WORD_W-1:0] vertex_x;
      logic signed [WORD_W-1:0] vertex_y;
      logic                     action;
   } res_slot_type;

endpackage

// ----- hdl/pvcd_stream_if.sv -----
// Valid/ready stream channel used for the vertex and result words.
// The word type is a parameter; no other dependencies.
interface pvcd_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ----- hdl/polyline_view_cull_decimate.sv -----
// Polyline view cull and decimate. Vertices of one polyline arrive one word per cycle while
// the block is ready and are registered; one pass of logic classifies the vertex against the
// view box, settles the vertex two places back and loads its results into a four-entry result
// buffer that drains one word per cycle while the output is ready. Ordinary vertices, which
// cause at most one result, stream at one per clock unless the output stalls; each passes
// through the input register and then the result buffer before its first result word.
// The final vertex of a polyline causes up to four results (pending flush and the closing
// word); the result buffer drains them in turn, and the input holds until the last is taken.
// Depends on pvcd_pkg and pvcd_stream_if.
module polyline_view_cull_decimate #(
   parameter int COORD_BITS = pvcd_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pvcd_stream_if.sink                         req_ch,
   pvcd_stream_if.source                       rsp_ch,
   input  logic                                csr_we,
   input  logic [pvcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pvcd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pvcd_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int CMP_W = ((CW > CSR_DATA_W + 1) ? CW : CSR_DATA_W + 1) + 1;
   localparam int CNT_W = $clog2(RES_MAX + 1);

   typedef logic signed [CW-1:0]    coord_type;
   typedef logic signed [CMP_W-1:0] cmp_type;
   typedef logic signed [CW:0]      dif_type;

   // Inside test against the box 0..lx, 0..ly.
   function automatic logic is_in(coord_type x, coord_type y, cmp_type lx, cmp_type ly);
      cmp_type xe;
      cmp_type ye;
      xe = cmp_type'(x);
      ye = cmp_type'(y);
      return (xe >= 0) && (xe <= lx) && (ye >= 0) && (ye <= ly);
   endfunction

   // Partial crossing test: straight left to right, or top to bottom.
   function automatic logic crosses(coord_type ax, coord_type ay, coord_type bx,
                                    coord_type by, cmp_type lx, cmp_type ly);
      cmp_type axe;
      cmp_type aye;
      cmp_type bxe;
      cmp_type bye;
      logic    lr;
      logic    tb;
      axe = cmp_type'(ax);
      aye = cmp_type'(ay);
      bxe = cmp_type'(bx);
      bye = cmp_type'(by);
      lr = (axe < 0) && (aye >= 0) && (aye <= ly) && (bxe > lx) && (bye >= 0) && (bye <= ly);
      tb = (aye < 0) && (axe >= 0) && (axe <= lx) && (bye > ly) && (bxe >= 0) && (bxe <= lx);
      return lr || tb;
   endfunction

   // Squared distance within the decimation radius.
   function automatic logic near(coord_type x, coord_type y, coord_type kx, coord_type ky);
      dif_type    dx;
      dif_type    dy;
      logic [7:0] sq;
      dx = dif_type'(x) - dif_type'(kx);
      dy = dif_type'(y) - dif_type'(ky);
      if (dx < 0) begin
         dx = -dx;
      end
      if (dy < 0) begin
         dy = -dy;
      end
      sq = 8'(dx[3:0]) * 8'(dx[3:0]) + 8'(dy[3:0]) * 8'(dy[3:0]);
      return (dx <= dif_type'(NEAR_DIST)) && (dy <= dif_type'(NEAR_DIST)) &&
             (sq <= 8'(NEAR_SQ));
   endfunction

   // Configuration registers.
   logic [CSR_DATA_W-1:0] view_w_ff;
   logic [CSR_DATA_W-1:0] view_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_w_ff <= VIEW_WIDTH_RESET;
         view_h_ff <= VIEW_HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_VIEW_WIDTH) begin
            view_w_ff <= csr_wdata;
         end else if (csr_index == CSR_VIEW_HEIGHT) begin
            view_h_ff <= csr_wdata;
         end
      end
   end

   // Box limits; a zero size gives a limit of -1.
   cmp_type lim_x;
   cmp_type lim_y;
   assign lim_x = cmp_type'(signed'({1'b0, view_w_ff})) - cmp_type'(1);
   assign lim_y = cmp_type'(signed'({1'b0, view_h_ff})) - cmp_type'(1);

   // Input register.
   logic      in_vld_ff;
   coord_type in_x_ff;
   coord_type in_y_ff;
   logic      in_last_ff;
   logic      grp_free;
   logic      take;

   assign req_ch.ready = !in_vld_ff || grp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_x_ff    <= coord_type'(req_ch.payload.point_x[CW-1:0]);
         in_y_ff    <= coord_type'(req_ch.payload.point_y[CW-1:0]);
         in_last_ff <= req_ch.payload.last_point;
      end
   end

   // Pending vertices and run state.
   coord_type pend_x_ff [2];
   coord_type pend_y_ff [2];
   logic      pend_ins_ff [2];
   logic      pend_keep_ff [2];
   logic [1:0] pend_cnt_ff;
   coord_type kept_x_ff;
   coord_type kept_y_ff;
   logic      run_start_ff;
   logic      run_open_ff;

   coord_type pend_x_in [2];
   coord_type pend_y_in [2];
   logic      pend_ins_in [2];
   logic      pend_keep_in [2];
   logic [1:0] pend_cnt_in;
   coord_type kept_x_in;
   coord_type kept_y_in;
   logic      run_start_in;
   logic      run_open_in;

   // Results of the vertex in the input register.
   res_slot_type    res [RES_MAX];
   logic [CNT_W-1:0] res_n;

   // Working signals of the pass.
   logic      two_pend;
   logic      ins_new;
   logic      keep_new;
   logic      pk0;
   logic      pk1;
   coord_type prv_x;
   coord_type prv_y;
   logic      prv_ins;
   coord_type q0_x;
   coord_type q0_y;
   logic      q0_ins;
   logic      q0_keep;
   logic      near0;
   logic      near1_k;
   logic      near1_a;
   coord_type s_x [3];
   coord_type s_y [3];
   logic      s_on [3];
   logic      s_keep [3];
   logic      s_nk [3];
   logic      s_fin [3];
   logic      s_near [3];
   logic      app0;
   logic      rs;
   logic      ro;

   assign two_pend = pend_cnt_ff[1];

   // Neighbor keep flags against the newest pending vertex.
   always_comb begin
      ins_new  = is_in(in_x_ff, in_y_ff, lim_x, lim_y);
      prv_x    = two_pend ? pend_x_ff[1] : pend_x_ff[0];
      prv_y    = two_pend ? pend_y_ff[1] : pend_y_ff[0];
      prv_ins  = two_pend ? pend_ins_ff[1] : pend_ins_ff[0];
      keep_new = ins_new;
      pk0      = pend_keep_ff[0];
      pk1      = pend_keep_ff[1];
      if (pend_cnt_ff != 2'd0) begin
         if (prv_ins || ins_new ||
             crosses(prv_x, prv_y, in_x_ff, in_y_ff, lim_x, lim_y)) begin
            if (two_pend) begin
               pk1 = 1'b1;
            end else begin
               pk0 = 1'b1;
            end
         end
         if (prv_ins ||
             (!ins_new && crosses(prv_x, prv_y, in_x_ff, in_y_ff, lim_x, lim_y))) begin
            keep_new = 1'b1;
         end
      end
   end

   // Oldest pending vertex after the shift, and the distance tests run side by side.
   always_comb begin
      q0_x    = two_pend ? pend_x_ff[1] : (pend_cnt_ff == 2'd1) ? pend_x_ff[0] : in_x_ff;
      q0_y    = two_pend ? pend_y_ff[1] : (pend_cnt_ff == 2'd1) ? pend_y_ff[0] : in_y_ff;
      q0_ins  = two_pend ? pend_ins_ff[1] : (pend_cnt_ff == 2'd1) ? pend_ins_ff[0] : ins_new;
      q0_keep = two_pend ? pk1 : (pend_cnt_ff == 2'd1) ? pk0 : keep_new;
      near0   = near(pend_x_ff[0], pend_y_ff[0], kept_x_ff, kept_y_ff);
      near1_k = near(q0_x, q0_y, kept_x_ff, kept_y_ff);
      near1_a = near(q0_x, q0_y, pend_x_ff[0], pend_y_ff[0]);
   end

   // Decision slots: the vertex two back, then on the final vertex the flush.
   always_comb begin
      s_on[0]   = two_pend;
      s_x[0]    = pend_x_ff[0];
      s_y[0]    = pend_y_ff[0];
      s_keep[0] = pk0;
      s_nk[0]   = pk1;
      s_fin[0]  = 1'b0;

      s_on[1]   = in_last_ff && (pend_cnt_ff != 2'd0);
      s_x[1]    = q0_x;
      s_y[1]    = q0_y;
      s_keep[1] = q0_keep;
      s_nk[1]   = keep_new;
      s_fin[1]  = 1'b0;

      s_on[2]   = in_last_ff;
      s_x[2]    = in_x_ff;
      s_y[2]    = in_y_ff;
      s_keep[2] = keep_new;
      s_nk[2]   = 1'b0;
      s_fin[2]  = 1'b1;
   end

   // Decide each slot in order and gather the results.
   always_comb begin
      for (int i = 0; i < RES_MAX; i++) begin
         res[i] = '0;
      end
      res_n     = '0;
      rs        = run_start_ff;
      ro        = run_open_ff;
      kept_x_in = kept_x_ff;
      kept_y_in = kept_y_ff;
      app0      = 1'b0;
      s_near[0] = near0;
      s_near[1] = 1'b0;
      s_near[2] = 1'b0;
      for (int s = 0; s < 3; s++) begin
         if (s == 1) begin
            s_near[1] = app0 ? near1_a : near1_k;
         end
         if (s_on[s]) begin
            if (!s_keep[s]) begin
               if (ro) begin
                  res[res_n[1:0]].action = ACT_CLOSE;
                  res_n = res_n + CNT_W'(1);
                  ro = 1'b0;
                  rs = 1'b1;
               end
            end else if (!(!rs && !s_fin[s] && s_nk[s] && s_near[s])) begin
               res[res_n[1:0]].vertex_x = WORD_W'(s_x[s]);
               res[res_n[1:0]].vertex_y = WORD_W'(s_y[s]);
               res[res_n[1:0]].action   = ACT_APPEND;
               res_n = res_n + CNT_W'(1);
               kept_x_in = s_x[s];
               kept_y_in = s_y[s];
               rs = 1'b0;
               ro = 1'b1;
               if (s == 0) begin
                  app0 = 1'b1;
               end
            end
         end
      end
      // The final vertex always ends with a closing word.
      if (in_last_ff) begin
         res[res_n[1:0]].action = ACT_CLOSE;
         res_n = res_n + CNT_W'(1);
         rs = 1'b1;
         ro = 1'b0;
      end
      run_start_in = rs;
      run_open_in  = ro;
   end

   // Pending list after the shift and insert.
   always_comb begin
      pend_x_in[0]    = q0_x;
      pend_y_in[0]    = q0_y;
      pend_ins_in[0]  = q0_ins;
      pend_keep_in[0] = q0_keep;
      pend_x_in[1]    = in_x_ff;
      pend_y_in[1]    = in_y_ff;
      pend_ins_in[1]  = ins_new;
      pend_keep_in[1] = keep_new;
      if (in_last_ff) begin
         pend_cnt_in = 2'd0;
      end else if (pend_cnt_ff == 2'd0) begin
         pend_cnt_in = 2'd1;
      end else begin
         pend_cnt_in = 2'd2;
      end
   end

   logic step;
   assign step = in_vld_ff && grp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff  <= 2'd0;
         run_start_ff <= 1'b1;
         run_open_ff  <= 1'b0;
      end else if (step) begin
         pend_cnt_ff  <= pend_cnt_in;
         run_start_ff <= run_start_in;
         run_open_ff  <= run_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pend_x_ff    <= pend_x_in;
         pend_y_ff    <= pend_y_in;
         pend_ins_ff  <= pend_ins_in;
         pend_keep_ff <= pend_keep_in;
         kept_x_ff    <= kept_x_in;
         kept_y_ff    <= kept_y_in;
      end
   end

   // Result buffer: a shift line whose head is the output word.
   res_slot_type     grp_ff [RES_MAX];
   logic [CNT_W-1:0] grp_cnt_ff;

   assign take     = (grp_cnt_ff != '0) && rsp_ch.ready;
   assign grp_free = (grp_cnt_ff == '0) || ((grp_cnt_ff == CNT_W'(1)) && rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= '0;
      end else if (step) begin
         grp_cnt_ff <= res_n;
      end else if (take) begin
         grp_cnt_ff <= grp_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         grp_ff <= res;
      end else if (take) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            grp_ff[i] <= grp_ff[i+1];
         end
      end
   end

   // Output word.
   assign rsp_ch.valid            = (grp_cnt_ff != '0);
   assign rsp_ch.payload.vertex_x = grp_ff[0].vertex_x;
   assign rsp_ch.payload.vertex_y = grp_ff[0].vertex_y;
   assign rsp_ch.payload.action   = grp_ff[0].action;
   assign rsp_ch.payload.run_last = (grp_cnt_ff == CNT_W'(1));

endmodule

// ----- hdl/pvcd_checker.sv -----
// Port-level checks for the polyline view cull and decimate block.
// Depends on pvcd_pkg; bound to the top level at the end of this file.
module pvcd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pvcd_pkg::rsp_word_type rsp_word
);
   import pvcd_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // A closing word carries zero coordinates.
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.action == ACT_CLOSE |->
         rsp_word.vertex_x == 0 && rsp_word.vertex_y == 0)
      else $error("closing word with nonzero coordinates");

   // Out of reset the block is empty and ready for a vertex.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind polyline_view_cull_decimate pvcd_checker u_pvcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_word  (rsp_ch.payload)
);

// ----- tb/pvcd_cmd_checker.sv -----
// Checker for the polyline view cull and decimate block: watches the vertex, result and
// register ports, predicts the append and close words and compares them as they arrive.
// Depends on pvcd_pkg.
`timescale 1ns / 100ps

module pvcd_cmd_checker #(
   parameter int COORD_BITS = pvcd_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pvcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pvcd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  pvcd_pkg::req_word_type           req_word,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  pvcd_pkg::rsp_word_type           rsp_word,
   output int                               mismatch_total,
   output int                               cmds_waiting
);
   import pvcd_pkg::*;

   // Shadow copy of the view registers.
   longint view_w;
   longint view_h;

   // Vertices whose keep decision is still open, oldest first.
   longint      held_x [2];
   longint      held_y [2];
   bit          held_in [2];
   bit          held_keep [2];
   int unsigned held_cnt;

   // Last vertex that went out as an append, and the run flags.
   longint anchor_x;
   longint anchor_y;
   bit     run_fresh;
   bit     run_live;

   // Draw commands caused by the current vertex, and all commands still owed.
   rsp_word_type step_cmds [$];
   rsp_word_type draw_cmd_q [$];
   int           fails;

   // Sign-extend the low COORD_BITS bits of a channel coordinate.
   function automatic longint to_coord(input logic signed [WORD_W-1:0] raw);
      longint v;
      v = longint'(raw);
      v = (v <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
      return v;
   endfunction

   function automatic bit in_view(input longint x, input longint y);
      return x >= 0 && x <= view_w - 1 && y >= 0 && y <= view_h - 1;
   endfunction

   // Partial crossing test: straight left to right, or straight top to bottom.
   function automatic bit spans_view(input longint ax, input longint ay,
                                     input longint bx, input longint by);
      longint lx;
      longint ly;
      lx = view_w - 1;
      ly = view_h - 1;
      if (ax < 0 && bx < 0) return 0;
      if (ax > lx && bx > lx) return 0;
      if (ay > ly && by > ly) return 0;
      if (ay < 0 && by < 0) return 0;
      if (ax < 0 && ay >= 0 && ay <= ly && bx > lx && by >= 0 && by <= ly) return 1;
      if (ay < 0 && ax >= 0 && ax <= lx && by > ly && bx >= 0 && bx <= lx) return 1;
      return 0;
   endfunction

   // Within the decimation radius of the last appended vertex.
   function automatic bit close_to_anchor(input longint x, input longint y);
      longint dx;
      longint dy;
      dx = x - anchor_x;
      dy = y - anchor_y;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx > NEAR_DIST || dy > NEAR_DIST) return 0;
      return dx * dx + dy * dy <= NEAR_SQ;
   endfunction

   task automatic push_cmd(input longint x, input longint y, input logic act);
      rsp_word_type w;
      w.vertex_x = x[WORD_W-1:0];
      w.vertex_y = y[WORD_W-1:0];
      w.action   = act;
      w.run_last = 1'b0;
      step_cmds  = {step_cmds, w};
   endtask

   // Settle one vertex: close the run, skip it as too close, or append it.
   task automatic settle(input longint x, input longint y, input bit keep,
                         input bit next_keep, input bit is_end);
      if (!keep) begin
         if (run_live) begin
            push_cmd(0, 0, ACT_CLOSE);
            run_live  = 0;
            run_fresh = 1;
         end
         return;
      end
      if (!run_fresh && !is_end && next_keep && close_to_anchor(x, y))
         return;
      push_cmd(x, y, ACT_APPEND);
      anchor_x  = x;
      anchor_y  = y;
      run_fresh = 0;
      run_live  = 1;
   endtask

   task automatic clear_held();
      for (int k = 0; k < 2; k++) begin
         held_x[k]    = 0;
         held_y[k]    = 0;
         held_in[k]   = 0;
         held_keep[k] = 0;
      end
      held_cnt = 0;
   endtask

   // Work out the draw commands that one accepted vertex causes.
   task automatic predict_vertex(input req_word_type w);
      longint      x;
      longint      y;
      bit          ins;
      bit          keep;
      int unsigned c;
      x    = to_coord(w.point_x);
      y    = to_coord(w.point_y);
      ins  = in_view(x, y);
      keep = ins;
      c    = held_cnt;
      step_cmds.delete();

      // The new vertex and its predecessor share keep reasons.
      if (c >= 1) begin
         if (held_in[c-1]) keep = 1;
         if (ins) held_keep[c-1] = 1;
         if (!held_in[c-1] && !ins && spans_view(held_x[c-1], held_y[c-1], x, y)) begin
            held_keep[c-1] = 1;
            keep           = 1;
         end
      end

      // The vertex two places back is now fully known.
      if (c == 2) begin
         settle(held_x[0], held_y[0], held_keep[0], held_keep[1], 0);
         held_x[0]    = held_x[1];
         held_y[0]    = held_y[1];
         held_in[0]   = held_in[1];
         held_keep[0] = held_keep[1];
         c            = 1;
      end
      held_x[c]    = x;
      held_y[c]    = y;
      held_in[c]   = ins;
      held_keep[c] = keep;
      c++;
      held_cnt = c;

      // The final vertex flushes everything and always closes.
      if (w.last_point) begin
         for (int unsigned k = 0; k < c; k++)
            settle(held_x[k], held_y[k], held_keep[k],
                   (k + 1 < c) ? held_keep[k+1] : 1'b0, k + 1 == c);
         push_cmd(0, 0, ACT_CLOSE);
         clear_held();
         run_live  = 0;
         run_fresh = 1;
      end

      if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].run_last = 1'b1;
      draw_cmd_q = {draw_cmd_q, step_cmds};
   endtask

   // Compare one arriving result word with the oldest command owed.
   task automatic check_cmd(input rsp_word_type got);
      rsp_word_type want;
      if (draw_cmd_q.size() == 0) begin
         fails++;
         if (fails <= 10)
            $display("%0t: unexpected word x=%0d y=%0d action=%0b run_last=%0b",
                     $realtime, got.vertex_x, got.vertex_y, got.action, got.run_last);
         return;
      end
      want = draw_cmd_q.pop_front();
      if (got.vertex_x !== want.vertex_x || got.vertex_y !== want.vertex_y ||
          got.action !== want.action || got.run_last !== want.run_last) begin
         fails++;
         if (fails <= 10)
            $display("%0t: mismatch expected x=%0d y=%0d action=%0b run_last=%0b,",
                     $realtime, want.vertex_x, want.vertex_y, want.action, want.run_last,
                     " got x=%0d y=%0d action=%0b run_last=%0b",
                     got.vertex_x, got.vertex_y, got.action, got.run_last);
      end
   endtask

   // Everything is sampled at the rising edge, before the edge's own updates land.
   always @(posedge clock) begin
      if (reset) begin
         view_w    = VIEW_WIDTH_RESET;
         view_h    = VIEW_HEIGHT_RESET;
         anchor_x  = 0;
         anchor_y  = 0;
         run_fresh = 1;
         run_live  = 0;
         clear_held();
         draw_cmd_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VIEW_WIDTH:  view_w = csr_wdata;
               CSR_VIEW_HEIGHT: view_h = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_vertex(req_word);
         if (rsp_valid && rsp_ready) check_cmd(rsp_word);
      end
      mismatch_total <= fails;
      cmds_waiting   <= draw_cmd_q.size();
   end

endmodule

// ----- tb/tb_polyline_view_cull_decimate.sv -----
// Top of the testbench for polyline_view_cull_decimate: drives vertex polylines and view
// settings, stalls the result side at random and gives the verdict.
// Depends on pvcd_pkg, pvcd_stream_if, the block and pvcd_cmd_checker.
`timescale 1ns / 100ps

module tb_polyline_view_cull_decimate;
   import pvcd_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 40;
   localparam int NUM_PHASES  = 8;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_total;
   int cmds_waiting;
   int idle_cycles;

   // Pacing controls for the sender and the receiver.
   bit tx_tight;
   bit rx_tight;
   bit long_hold_req;

   pvcd_stream_if #(.payload_type(req_word_type)) req_ch ();
   pvcd_stream_if #(.payload_type(rsp_word_type)) rsp_ch ();

   polyline_view_cull_decimate DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pvcd_cmd_checker CHECK (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_word       (req_ch.payload),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_word       (rsp_ch.payload),
      .mismatch_total (mismatch_total),
      .cmds_waiting   (cmds_waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one vertex after a random gap (none when tx_tight is set) and wait until it is taken.
   task automatic send_vertex(input logic signed [WORD_W-1:0] x,
                              input logic signed [WORD_W-1:0] y, input logic is_end);
      int gap;
      gap = tx_tight ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.payload.point_x    <= x;
      req_ch.payload.point_y    <= y;
      req_ch.payload.last_point <= is_end;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Change the view box once the block has gone quiet.
   task automatic write_view(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (cmds_waiting != 0);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_VIEW_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_VIEW_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Next coordinate: mostly around the box, some on its borders, some small steps
   // from the previous vertex to exercise decimation, a few anywhere.
   function automatic logic signed [WORD_W-1:0] roam_coord(input logic signed [WORD_W-1:0] prev,
                                                           input int span);
      int pick;
      int reach;
      pick  = $urandom_range(0, 9);
      reach = span + 16;
      case (pick)
         0: roam_coord = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       roam_coord = -1;
               1:       roam_coord = 0;
               2:       roam_coord = span - 1;
               default: roam_coord = span;
            endcase
         end
         2, 3, 4: roam_coord = prev + (int'($urandom_range(0, 18)) - 9);
         default: roam_coord = int'($urandom_range(0, 3 * reach)) - reach;
      endcase
   endfunction

   // Result side: a random stall before every word unless rx_tight is set, one long hold-off on request.
   initial begin
      int stall;
      bit hold_done;
      hold_done    = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rx_tight = !rx_tight;
         stall = rx_tight ? 0 : $urandom_range(0, 14);
         if (long_hold_req && !hold_done) begin
            hold_done = 1;
            stall     = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus: directed polylines under the reset view, then random phases.
   initial begin
      logic signed [WORD_W-1:0] prev_x;
      logic signed [WORD_W-1:0] prev_y;
      int                       cur_w;
      int                       cur_h;
      int                       sent;
      int                       len;
      tx_tight       = 0;
      long_hold_req  = 0;
      prev_x         = 0;
      prev_y         = 0;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_VIEW_WIDTH;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single inside vertex: one append, then the close.
      send_vertex(10, 10, 1);
      // Coordinate extremes, both far outside: only the close.
      send_vertex(32'sh8000_0000, 32'sh8000_0000, 0);
      send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 1);
      // Segment crossing left to right, then one crossing top to bottom.
      send_vertex(-5, 100, 0);
      send_vertex(700, 100, 1);
      send_vertex(100, -5, 0);
      send_vertex(100, 500, 1);
      // Close neighbors that decimation should drop.
      send_vertex(50, 50, 0);
      send_vertex(52, 52, 0);
      send_vertex(54, 54, 0);
      send_vertex(100, 100, 0);
      send_vertex(300, 300, 1);
      // A run closed by unkept vertices, then a new run.
      send_vertex(10, 10, 0);
      send_vertex(20, 20, 0);
      send_vertex(-100, -100, 0);
      send_vertex(-200, -200, 0);
      send_vertex(-300, -300, 0);
      send_vertex(30, 30, 0);
      send_vertex(40, 40, 1);
      // Distance exactly on the decimation radius.
      send_vertex(200, 200, 0);
      send_vertex(208, 200, 0);
      send_vertex(216, 200, 0);
      send_vertex(400, 400, 1);
      // Last inside corner next to the first outside one.
      send_vertex(639, 479, 0);
      send_vertex(640, 480, 1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       begin cur_w = 1;     cur_h = 1;     end
            1:       begin cur_w = 65535; cur_h = 65535; end
            2:       begin cur_w = 0;     cur_h = 5;     end
            3:       begin cur_w = 32;    cur_h = 24;    end
            4:       begin cur_w = 100;   cur_h = 1;     end
            5:       begin cur_w = 1;     cur_h = 100;   end
            6:       begin cur_w = 16;    cur_h = 0;     end
            default: begin cur_w = 640;   cur_h = 480;   end
         endcase
         write_view(cur_w[CSR_DATA_W-1:0], cur_h[CSR_DATA_W-1:0]);
         // One phase runs the sender flat out against a long result hold-off.
         if (p == 3) long_hold_req = 1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 14);
            tx_tight = (p == 3) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
               prev_x = roam_coord(prev_x, cur_w);
               prev_y = roam_coord(prev_y, cur_h);
               send_vertex(prev_x, prev_y, k == len - 1);
            end
            sent += len;
         end
      end

      // Drain and give the verdict.
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (cmds_waiting != 0);
      repeat (10) @(posedge clock);
      if (mismatch_total == 0 && cmds_waiting == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
